>>> rtl/core/idec_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// idec_pkg
// Shared types, constants and timing tables of the IDE mode timing calculator.
// ----------------------------------------------------------------------------
package idec_pkg;

  localparam int unsigned NS_W    = 10;
  localparam int unsigned PROD_W  = 20;
  localparam int unsigned CYC_W   = 10;
  localparam int unsigned CPU_W   = 10;
  localparam int unsigned LANES   = 5;
  localparam int unsigned FIELD_W = 8;

  localparam logic [CPU_W-1:0] CPU_RESET = 10'd80;

  // floor(p / 1000) == (p * RECIP_1000) >> RECIP_SHIFT for p < 2**20
  localparam logic [20:0] RECIP_1000  = 21'd1073742;
  localparam int unsigned RECIP_SHIFT = 30;
  localparam int unsigned RECIP_W     = 41;

  // floor(d / 3) == (d * RECIP_3) >> DIV3_SHIFT for d < 2048
  localparam logic [CYC_W-1:0] RECIP_3    = 10'd683;
  localparam int unsigned      DIV3_SHIFT = 11;

  localparam logic [3:0] PIO_MODE_MAX = 4'd4;
  localparam logic [3:0] DMA_MODE_MAX = 4'd2;

  localparam logic ACT_PIO = 1'b0;
  localparam logic ACT_DMA = 1'b1;

  typedef logic [LANES-1:0][NS_W-1:0]  ns_set_t;
  typedef logic [LANES-1:0][CYC_W-1:0] cyc_set_t;

  typedef struct packed {
    logic       action;
    logic [3:0] mode;
  } req_t;

  typedef struct packed {
    logic [31:0] timing_word;
    logic        is_dma;
    logic        mode_error;
    logic        field_overflow;
  } rsp_t;

  typedef struct packed {
    logic     valid;
    logic     action;
    logic     err;
    cyc_set_t cyc;
  } scaled_t;

  function automatic ns_set_t pack5(input logic [NS_W-1:0] a, input logic [NS_W-1:0] b,
                                    input logic [NS_W-1:0] c, input logic [NS_W-1:0] d,
                                    input logic [NS_W-1:0] e);
    return {e, d, c, b, a};
  endfunction

  // lane 0 cycle time, then t1 t2 t2l (pio) or tkw tkr td tm (dma)
  function automatic ns_set_t lookup_ns(input logic action, input logic [3:0] mode);
    ns_set_t s;
    s = '0;
    if (action == ACT_PIO) begin
      case (mode)
        4'd0:    s = pack5(10'd600, 10'd70, 10'd165, 10'd0, 10'd0);
        4'd1:    s = pack5(10'd383, 10'd50, 10'd125, 10'd0, 10'd0);
        4'd2:    s = pack5(10'd240, 10'd30, 10'd100, 10'd0, 10'd0);
        4'd3:    s = pack5(10'd180, 10'd30, 10'd80, 10'd70, 10'd0);
        4'd4:    s = pack5(10'd120, 10'd25, 10'd70, 10'd25, 10'd0);
        default: s = '0;
      endcase
    end else begin
      case (mode)
        4'd0:    s = pack5(10'd480, 10'd215, 10'd50, 10'd215, 10'd50);
        4'd1:    s = pack5(10'd150, 10'd50, 10'd50, 10'd80, 10'd30);
        default: s = pack5(10'd120, 10'd25, 10'd25, 10'd70, 10'd25);
      endcase
    end
    return s;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/idec_scale.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// idec_scale
// Table lookup, ns times clock rate, and divide by 1000 over three stages.
// ----------------------------------------------------------------------------
module idec_scale (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          valid_i,
  input  wire idec_pkg::req_t                req_i,
  input  wire logic [idec_pkg::CPU_W-1:0]    cpu_i,
  output idec_pkg::scaled_t                  scaled_o
);
  import idec_pkg::*;

  logic                  va_q, vb_q, vc_q;
  logic                  act_a_q, act_b_q, act_c_q;
  logic                  err_a_q, err_b_q, err_c_q;
  ns_set_t               ns_d, ns_q;
  logic [PROD_W-1:0]     prod_d [LANES];
  logic [PROD_W-1:0]     prod_q [LANES];
  logic [RECIP_W-1:0]    quot_full [LANES];
  cyc_set_t              cyc_d, cyc_q;
  logic                  err_d;

  assign err_d = (req_i.action == ACT_PIO) && (req_i.mode > PIO_MODE_MAX);
  assign ns_d  = lookup_ns(req_i.action, req_i.mode);

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      prod_d[i]    = PROD_W'(ns_q[i]) * PROD_W'(cpu_i);
      quot_full[i] = RECIP_W'(prod_q[i]) * RECIP_W'(RECIP_1000);
      cyc_d[i]     = quot_full[i][RECIP_SHIFT +: CYC_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    act_a_q <= req_i.action;
    err_a_q <= err_d;
    ns_q    <= ns_d;
    act_b_q <= act_a_q;
    err_b_q <= err_a_q;
    for (int i = 0; i < LANES; i++) begin
      prod_q[i] <= prod_d[i];
    end
    act_c_q <= act_b_q;
    err_c_q <= err_b_q;
    cyc_q   <= cyc_d;
  end

  assign scaled_o.valid  = vc_q;
  assign scaled_o.action = act_c_q;
  assign scaled_o.err    = err_c_q;
  assign scaled_o.cyc    = cyc_q;

endmodule
`default_nettype wire

>>> rtl/core/idec_adjust.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// idec_adjust
// Cycle time shortfall, spread over the fields, packing and overflow check.
// ----------------------------------------------------------------------------
module idec_adjust (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire idec_pkg::scaled_t   scaled_i,
  output logic                     done_o,
  output idec_pkg::rsp_t           rsp_o
);
  import idec_pkg::*;

  logic [CYC_W:0]    t0p;
  logic [CYC_W+1:0]  sum;
  logic [CYC_W:0]    kw_sum, kr_sum;
  logic [CYC_W-1:0]  a_d, b_d, c_d, e_d, def_d;
  logic [CYC_W-1:0]  a_q, b_q, c_q, e_q, def_q;
  logic              vd_q, act_q, err_q;

  logic [2*CYC_W-1:0] q_full;
  logic [CYC_W-1:0]   q;
  logic [CYC_W:0]     q3;
  logic [1:0]         rem;
  logic [CYC_W:0]     x1, x2, x3, x4;
  logic               ovf;
  rsp_t               rsp_d, rsp_q;
  logic               done_q;

  // stage d: shortfall against the cycle time
  always_comb begin
    t0p    = (CYC_W+1)'(scaled_i.cyc[0]) + (CYC_W+1)'(1);
    sum    = (CYC_W+2)'(scaled_i.cyc[1]) + (CYC_W+2)'(scaled_i.cyc[2]) +
             (CYC_W+2)'(scaled_i.cyc[3]);
    kw_sum = (CYC_W+1)'(scaled_i.cyc[1]) + (CYC_W+1)'(scaled_i.cyc[3]);
    kr_sum = (CYC_W+1)'(scaled_i.cyc[2]) + (CYC_W+1)'(scaled_i.cyc[3]);
    a_d    = scaled_i.cyc[1];
    b_d    = scaled_i.cyc[2];
    c_d    = scaled_i.cyc[3];
    e_d    = scaled_i.cyc[4];
    def_d  = '0;
    if (scaled_i.action == ACT_PIO) begin
      if (sum < (CYC_W+2)'(t0p)) begin
        def_d = CYC_W'((CYC_W+2)'(t0p) - sum);
      end
    end else begin
      if (kw_sum < t0p) begin
        a_d = CYC_W'(t0p - (CYC_W+1)'(scaled_i.cyc[3]));
      end
      if (kr_sum < t0p) begin
        b_d = CYC_W'(t0p - (CYC_W+1)'(scaled_i.cyc[3]));
      end
    end
  end

  // stage e: spread and pack
  always_comb begin
    q_full = (2*CYC_W)'(def_q) * (2*CYC_W)'(RECIP_3);
    q      = q_full[DIV3_SHIFT +: CYC_W];
    q3     = {q, 1'b0} + (CYC_W+1)'(q);
    rem    = 2'((CYC_W+1)'(def_q) - q3);
    x1     = (CYC_W+1)'(a_q) + (CYC_W+1)'(q);
    x2     = (CYC_W+1)'(b_q) + (CYC_W+1)'(q) + (CYC_W+1)'(rem != 2'd0);
    x3     = (CYC_W+1)'(c_q) + (CYC_W+1)'(q) + (CYC_W+1)'(rem == 2'd2);
    x4     = (CYC_W+1)'(e_q);
    ovf    = 1'b0;
    rsp_d  = '0;
    if (err_q) begin
      rsp_d.mode_error = 1'b1;
    end else if (act_q == ACT_PIO) begin
      ovf                  = (x1 > 11'd255) || (x2 > 11'd255) || (x3 > 11'd255);
      rsp_d.timing_word    = {8'd0, x3[FIELD_W-1:0], x2[FIELD_W-1:0], x1[FIELD_W-1:0]};
      rsp_d.field_overflow = ovf;
    end else begin
      ovf                  = (x1 > 11'd255) || (x2 > 11'd255) || (x3 > 11'd255) ||
                             (x4 > 11'd255);
      rsp_d.timing_word    = {x1[FIELD_W-1:0], x2[FIELD_W-1:0], x3[FIELD_W-1:0],
                              x4[FIELD_W-1:0]};
      rsp_d.is_dma         = 1'b1;
      rsp_d.field_overflow = ovf;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      vd_q   <= scaled_i.valid;
      done_q <= vd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q <= scaled_i.action;
    err_q <= scaled_i.err;
    a_q   <= a_d;
    b_q   <= b_d;
    c_q   <= c_d;
    e_q   <= e_d;
    def_q <= def_d;
    rsp_q <= rsp_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  a_stage_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vd_q |=> done_q)
    else $error("stage word not delivered");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && rsp_q.mode_error |-> rsp_q.timing_word == 32'd0 && !rsp_q.field_overflow)
    else $error("mode error word not cleared");

  a_err_pio: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && rsp_q.mode_error |-> !rsp_q.is_dma)
    else $error("mode error on dma word");

  a_pio_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && !rsp_q.is_dma |-> rsp_q.timing_word[31:24] == 8'd0)
    else $error("pio word top byte set");

endmodule
`default_nettype wire

>>> rtl/core/ide_mode_timing_calculator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ide_mode_timing_calculator_top
// IDE PIO / multiword DMA timing word calculator.
//
// A request word (action, mode) is taken at a clock edge with start high and
// busy low; busy is always low, so a request may be issued every cycle.
// Each request gives one result word on rsp_o, marked by done for exactly
// one cycle, after the registered lookup, multiply, divide by 1000,
// shortfall, and spread and pack stages. Throughput is one word a cycle.
// The receiver cannot stall; results appear in request order.
// cfg_we_i / cfg_wdata_i write the clock cycles per microsecond register,
// to be written only while no request is in flight.
// Reset clears the pipeline valid bits and sets the rate register to 80.
// ----------------------------------------------------------------------------
module ide_mode_timing_calculator_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire idec_pkg::req_t                req_i,
  output logic                               done,
  output idec_pkg::rsp_t                     rsp_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [idec_pkg::CPU_W-1:0]    cfg_wdata_i
);
  import idec_pkg::*;

  logic [CPU_W-1:0] cpu_q;
  scaled_t          scaled;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpu_q <= CPU_RESET;
    end else if (cfg_we_i) begin
      cpu_q <= cfg_wdata_i;
    end
  end

  assign busy = 1'b0;

  idec_scale u_scale (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (start & ~busy),
    .req_i    (req_i),
    .cpu_i    (cpu_q),
    .scaled_o (scaled)
  );

  idec_adjust u_adjust (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .scaled_i (scaled),
    .done_o   (done),
    .rsp_o    (rsp_o)
  );

endmodule
`default_nettype wire

>>> tb/ide_mode_timing_calculator_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ide_mode_timing_calculator_top_test
// Self-checking bench for the IDE PIO / multiword DMA timing calculator.
// Requests are issued with random gaps, and each one is turned into an
// expected timing word by a local model of the ATA timing tables. Every done
// word is compared field by field with the oldest expected word. The rate
// register is swept through its extremes and random values, always with the
// pipeline drained.
// ----------------------------------------------------------------------------
module ide_mode_timing_calculator_top_test;

  import idec_pkg::*;

  localparam int unsigned RANDOM_PHASES    = 8;
  localparam int unsigned ITEMS_PER_PHASE  = 225;
  localparam int unsigned DRAIN_CYCLES     = 10;
  localparam time         RUN_LIMIT        = 5ms;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  req_t                 req_i;
  logic                 done;
  rsp_t                 rsp_o;
  logic                 cfg_we_i;
  logic [CPU_W-1:0]     cfg_wdata_i;

  rsp_t                 timing_words_due[$];
  logic [CPU_W-1:0]     rate_cfg;
  int unsigned          mismatch_count;
  bit                   burst_mode;

  ide_mode_timing_calculator_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .done        (done),
    .rsp_o       (rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // nanosecond tables, lane 0 is the cycle time
  function automatic int unsigned timing_ns(input logic dma, input int unsigned m,
                                            input int unsigned lane);
    logic [4:0][9:0] row;
    row = '0;
    if (dma == ACT_PIO) begin
      case (m)
        0: row = {10'd0, 10'd0,  10'd165, 10'd70, 10'd600};
        1: row = {10'd0, 10'd0,  10'd125, 10'd50, 10'd383};
        2: row = {10'd0, 10'd0,  10'd100, 10'd30, 10'd240};
        3: row = {10'd0, 10'd70, 10'd80,  10'd30, 10'd180};
        4: row = {10'd0, 10'd25, 10'd70,  10'd25, 10'd120};
        default: row = '0;
      endcase
    end else begin
      case (m)
        0: row = {10'd50, 10'd215, 10'd50, 10'd215, 10'd480};
        1: row = {10'd30, 10'd80,  10'd50, 10'd50,  10'd150};
        default: row = {10'd25, 10'd70, 10'd25, 10'd25, 10'd120};
      endcase
    end
    return int'(row[lane]);
  endfunction

  function automatic rsp_t predict_timing(input req_t r, input logic [CPU_W-1:0] rate);
    rsp_t        w;
    int unsigned cyc[5];
    int unsigned m;
    int unsigned sum;
    int unsigned d;
    int unsigned q;
    w = '0;
    w.is_dma = r.action;
    if (r.action == ACT_PIO && r.mode > PIO_MODE_MAX) begin
      w.is_dma     = 1'b0;
      w.mode_error = 1'b1;
      return w;
    end
    m = (r.action == ACT_DMA && r.mode > DMA_MODE_MAX) ? int'(DMA_MODE_MAX) : int'(r.mode);
    for (int i = 0; i < 5; i++) begin
      cyc[i] = (timing_ns(r.action, m, i) * int'(rate)) / 1000;
    end
    cyc[0] += 1;
    if (r.action == ACT_PIO) begin
      // t1 t2 t2l in lanes 1..3, shortfall spread over t2, t2l, t1
      sum = cyc[1] + cyc[2] + cyc[3];
      if (sum < cyc[0]) begin
        d = cyc[0] - sum;
        q = d / 3;
        cyc[1] += q;
        cyc[2] += q + ((d % 3 >= 1) ? 1 : 0);
        cyc[3] += q + ((d % 3 >= 2) ? 1 : 0);
      end
      w.timing_word    = {8'h00, cyc[3][7:0], cyc[2][7:0], cyc[1][7:0]};
      w.field_overflow = (cyc[1] > 255) || (cyc[2] > 255) || (cyc[3] > 255);
    end else begin
      // tkw tkr td tm in lanes 1..4
      if (cyc[1] + cyc[3] < cyc[0]) cyc[1] = cyc[0] - cyc[3];
      if (cyc[2] + cyc[3] < cyc[0]) cyc[2] = cyc[0] - cyc[3];
      w.timing_word    = {cyc[1][7:0], cyc[2][7:0], cyc[3][7:0], cyc[4][7:0]};
      w.field_overflow = (cyc[1] > 255) || (cyc[2] > 255) || (cyc[3] > 255) ||
                         (cyc[4] > 255);
    end
    return w;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin
    rsp_t exp_w;
    if (rst_ni && done) begin
      if (timing_words_due.size() == 0) begin
        report_mismatch($sformatf("unexpected word %0h", rsp_o));
      end else begin
        exp_w = timing_words_due.pop_front();
        if (rsp_o.timing_word !== exp_w.timing_word)
          report_mismatch($sformatf("timing_word %0h, expected %0h",
                                    rsp_o.timing_word, exp_w.timing_word));
        if (rsp_o.is_dma !== exp_w.is_dma)
          report_mismatch($sformatf("is_dma %b, expected %b", rsp_o.is_dma, exp_w.is_dma));
        if (rsp_o.mode_error !== exp_w.mode_error)
          report_mismatch($sformatf("mode_error %b, expected %b",
                                    rsp_o.mode_error, exp_w.mode_error));
        if (rsp_o.field_overflow !== exp_w.field_overflow)
          report_mismatch($sformatf("field_overflow %b, expected %b",
                                    rsp_o.field_overflow, exp_w.field_overflow));
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (burst_mode || roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_request(input logic act, input logic [3:0] m);
    req_t        r;
    int unsigned gap;
    r.action = act;
    r.mode   = m;
    start <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    timing_words_due.push_back(predict_timing(r, rate_cfg));
    gap = pick_gap();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // drains the pipeline before the rate changes
  task automatic set_rate(input logic [CPU_W-1:0] v);
    start <= 1'b0;
    while (timing_words_due.size() != 0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    rate_cfg = v;
  endtask

  task automatic test_reset_rate();
    for (int m = 0; m <= 4; m++) send_request(ACT_PIO, 4'(m));
    send_request(ACT_PIO, 4'd5);
    send_request(ACT_PIO, 4'd15);
    for (int m = 0; m <= 3; m++) send_request(ACT_DMA, 4'(m));
    send_request(ACT_DMA, 4'd15);
  endtask

  task automatic test_rate_extremes();
    // zero rate leaves only the extra cycle
    set_rate(10'd0);
    send_request(ACT_PIO, 4'd0);
    send_request(ACT_DMA, 4'd0);
    // full scale, fields may exceed their byte and wrap
    set_rate(10'd1023);
    send_request(ACT_PIO, 4'd0);
    send_request(ACT_PIO, 4'd4);
    send_request(ACT_DMA, 4'd0);
    send_request(ACT_DMA, 4'd2);
    set_rate(10'd1);
    send_request(ACT_PIO, 4'd4);
    send_request(ACT_DMA, 4'd2);
    set_rate(10'd1000);
    send_request(ACT_PIO, 4'd3);
    send_request(ACT_DMA, 4'd1);
  endtask

  task automatic test_random_traffic();
    logic [CPU_W-1:0] rate;
    logic             act;
    logic [3:0]       m;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0:       rate = 10'd1000;
        1:       rate = 10'd1;
        2:       rate = 10'd1023;
        3:       rate = 10'd0;
        4:       rate = 10'd80;
        default: rate = 10'($urandom_range(0, 1023));
      endcase
      set_rate(rate);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (i % 50 == 0) burst_mode = ($urandom_range(0, 2) == 0);
        act = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 99) < 85)
          m = 4'($urandom_range(0, (act == ACT_PIO) ? PIO_MODE_MAX : DMA_MODE_MAX));
        else
          m = 4'($urandom_range(0, 15));
        send_request(act, m);
      end
      burst_mode = 1'b0;
    end
  endtask

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    start          = 1'b0;
    req_i          = '0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    rate_cfg       = CPU_RESET;
    mismatch_count = 0;
    burst_mode     = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_rate();
    test_rate_extremes();
    test_random_traffic();

    start <= 1'b0;
    while (timing_words_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT);
    $display("timeout, %0d words outstanding", timing_words_due.size());
    $display("FAIL");
    $finish;
  end

endmodule
